@@ rtl/acpe_pkg.sv @@
package acpe_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	// raw pair colors and fixed output codes
	localparam logic [1:0] COLOR_BLACK  = 2'd0;
	localparam logic [1:0] COLOR_BLUE   = 2'd1;
	localparam logic [1:0] COLOR_ORANGE = 2'd2;
	localparam logic [1:0] COLOR_WHITE  = 2'd3;

	// configuration register indexes
	localparam logic CFG_ARTIFACT_MODE    = 1'b0;
	localparam logic CFG_BLUE_IS_CODE_ONE = 1'b1;

	typedef struct packed {
		logic artifact_mode;
		logic blue_is_code_one;
	} cfg_t;

	// one word to expand, with its neighbor context
	typedef struct packed {
		logic [7:0] byte_val;
		logic       prev_ok;
		logic [1:0] prev;
		logic       has_next;
		logic [1:0] next;
	} word_job_t;

	// one queue entry: one or two words caused by one input transfer
	typedef struct packed {
		logic      two;
		logic      row_end;
		word_job_t w0;
		word_job_t w1;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [1:0] color_code(logic [1:0] raw, cfg_t c);
		logic [1:0] code;
		code = raw;
		if (raw == COLOR_BLUE) begin
			code = c.blue_is_code_one ? COLOR_BLUE : COLOR_ORANGE;
		end else if (raw == COLOR_ORANGE) begin
			code = c.blue_is_code_one ? COLOR_ORANGE : COLOR_BLUE;
		end
		return code;
	endfunction

	function automatic logic [15:0] expand_word(word_job_t j, cfg_t c);
		logic [15:0] word;
		logic [11:0] seq;
		logic [1:0]  raw;
		logic [1:0]  prv;
		logic [1:0]  nxt;
		logic        prev_ok;
		logic        next_ok;
		logic [1:0]  p0;
		logic [1:0]  p1;
		word = '0;
		// left neighbor, the four pairs, right neighbor
		seq  = {j.prev, j.byte_val, j.next};
		for (int k = 0; k < 4; k++) begin
			raw     = seq[9-2*k -: 2];
			prev_ok = (k > 0) ? 1'b1 : j.prev_ok;
			prv     = seq[11-2*k -: 2];
			next_ok = (k < 3) ? 1'b1 : j.has_next;
			nxt     = seq[7-2*k -: 2];
			if (c.artifact_mode) begin
				p0 = (raw != COLOR_BLACK) ? COLOR_BLUE : COLOR_BLACK;
				p1 = p0;
			end else begin
				p0 = color_code(raw, c);
				p1 = p0;
				if (raw == COLOR_BLUE && next_ok &&
				    (nxt == COLOR_ORANGE || nxt == COLOR_WHITE)) begin
					p0 = COLOR_BLACK;
					p1 = COLOR_WHITE;
				end else if (raw == COLOR_ORANGE && prev_ok &&
				             (prv == COLOR_BLUE || prv == COLOR_WHITE)) begin
					p0 = COLOR_WHITE;
					p1 = COLOR_BLACK;
				end
			end
			word[15-4*k -: 4] = {p0, p1};
		end
		return word;
	endfunction

endpackage

@@ rtl/acpe_front.sv @@
module acpe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          source_byte,
	input  logic                row_end,
	output logic                push,
	output acpe_pkg::job_t      job
);

	logic [7:0] held_byte_q;
	logic       held_valid_q;
	logic [1:0] prior_color_q;
	logic       prior_valid_q;

	acpe_pkg::word_job_t held_word;
	acpe_pkg::word_job_t new_word;

	always_comb begin
		held_word.byte_val = held_byte_q;
		held_word.prev_ok  = prior_valid_q;
		held_word.prev     = prior_color_q;
		held_word.has_next = 1'b1;
		held_word.next     = source_byte[7:6];

		// the new byte follows the held one when there is one
		new_word.byte_val = source_byte;
		new_word.prev_ok  = held_valid_q | prior_valid_q;
		new_word.prev     = held_valid_q ? held_byte_q[1:0] : prior_color_q;
		new_word.has_next = 1'b0;
		new_word.next     = acpe_pkg::COLOR_BLACK;

		job.two     = held_valid_q & row_end;
		job.row_end = row_end;
		job.w0      = held_valid_q ? held_word : new_word;
		job.w1      = new_word;
		push        = accept & (held_valid_q | row_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q   <= '0;
			held_valid_q  <= 1'b0;
			prior_color_q <= acpe_pkg::COLOR_BLACK;
			prior_valid_q <= 1'b0;
		end else if (accept) begin
			held_valid_q <= ~row_end;
			if (!row_end) begin
				held_byte_q <= source_byte;
			end
			if (row_end) begin
				prior_color_q <= acpe_pkg::COLOR_BLACK;
				prior_valid_q <= 1'b0;
			end else if (held_valid_q) begin
				prior_color_q <= held_byte_q[1:0];
				prior_valid_q <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/acpe_queue.sv @@
module acpe_queue #(
	parameter int DEPTH = acpe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  acpe_pkg::job_t     push_job,
	input  logic               pop,
	output acpe_pkg::job_t     head_job,
	output acpe_pkg::q_stat_t  stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	acpe_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign head_job   = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/acpe_back.sv @@
module acpe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  acpe_pkg::cfg_t     cfg,
	input  acpe_pkg::job_t     head_job,
	input  logic               avail,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        pixel_word,
	output logic               ends_row,
	output logic               last
);

	logic                phase_q;
	logic                out_valid_q;
	logic [15:0]         word_q;
	logic                ends_row_q;
	logic                last_q;
	logic                load;
	logic                is_final;
	acpe_pkg::word_job_t sel;

	always_comb begin
		load     = avail & (~out_valid_q | out_ready);
		is_final = ~head_job.two | phase_q;
		sel      = phase_q ? head_job.w1 : head_job.w0;
		pop      = load & is_final;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q     <= acpe_pkg::expand_word(sel, cfg);
			ends_row_q <= is_final & head_job.row_end;
			last_q     <= is_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q     <= ~is_final;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_word = word_q;
	assign ends_row   = ends_row_q;
	assign last       = last_q;

endmodule

@@ rtl/artifact_color_pixel_expander.sv @@
// A word passes the job queue and then the output register on its way out; the second word
// of a row-end transfer follows the first. Throughput: one byte per cycle while the queue
// has room; a row-end transfer behind a held byte yields two words, which the single output
// register sends one per cycle while out_ready is high, the job queue absorbing the extra
// word. Reset: arst_n asynchronously clears held byte, row context, queue and output valid,
// and sets artifact_mode to 0 and blue_is_code_one to 1.
module artifact_color_pixel_expander #(
	parameter int QUEUE_DEPTH = acpe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	// source byte channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  source_byte,
	input  logic        row_end,
	// pixel word channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pixel_word,
	output logic        ends_row,
	output logic        last
);

	acpe_pkg::cfg_t    cfg_q;
	acpe_pkg::job_t    push_job;
	acpe_pkg::job_t    head_job;
	acpe_pkg::q_stat_t q_stat;
	logic              accept;
	logic              push;
	logic              pop;

	// Configuration registers: the user must write them only while the block is idle; the
	// block does not enforce it. Read by the back part at the moment a word is expanded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.artifact_mode    <= 1'b0;
			cfg_q.blue_is_code_one <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				acpe_pkg::CFG_ARTIFACT_MODE:    cfg_q.artifact_mode    <= cfg_data;
				acpe_pkg::CFG_BLUE_IS_CODE_ONE: cfg_q.blue_is_code_one <= cfg_data;
				default: ;
			endcase
		end
	end

	// Accept a byte whenever the queue has room; bytes that only get held
	// take no queue slot.
	assign in_ready = ~q_stat.full;
	assign accept   = in_valid & in_ready;

	// Front: hold each byte until its lookahead arrives, track the row context and
	// turn each transfer that releases words into one queue entry of one or two words.
	acpe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.source_byte (source_byte),
		.row_end     (row_end),
		.push        (push),
		.job         (push_job)
	);

	// Short job queue: lets the front keep taking bytes while the output stalls.
	acpe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.stat     (q_stat)
	);

	// Back: while a job waits and the output is free or taken, expand one word per cycle into
	// the output register, advancing to a two-word entry's second word before dropping it.
	acpe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_job   (head_job),
		.avail      (~q_stat.empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_word (pixel_word),
		.ends_row   (ends_row),
		.last       (last)
	);

	// A word that ends a row is always the final word of its transfer.
	a_ends_row_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ends_row |-> last)
		else $error("ends_row without last");

	// The first word of a pair is always followed by the second one.
	a_pair_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |=> out_valid)
		else $error("second word of a pair missing");

	// Queue status stays consistent.
	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue both full and empty");

	// Nothing is pushed into a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("push into full queue");

endmodule
